// ===== design/csvs_pkg.sv =====
package csvs_pkg;

    localparam int CNT_W = 7;
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [2:0]
    {
        CMD_NONE,
        CMD_STORE,
        CMD_TEXT,
        CMD_OVF,
        CMD_END
    } cmd_kind_t;

    // count: flush length for text, store slot for whitespace
    typedef struct packed
    {
        cmd_kind_t        kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             eol;
    } cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
    endfunction

endpackage

// ===== design/csvs_if.sv =====
interface csv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_byte_valid;
    logic       end_of_line;

    modport source (output valid, in_byte, in_byte_valid, end_of_line, input ready);
    modport sink (input valid, in_byte, in_byte_valid, end_of_line, output ready);
endinterface

interface csv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       field_done;
    logic       line_done;
    logic       space_overflow;
    logic       last_result;

    modport source
    (
        output valid, out_byte, out_byte_valid, field_done, line_done, space_overflow,
        last_result,
        input ready
    );
    modport sink
    (
        input valid, out_byte, out_byte_valid, field_done, line_done, space_overflow,
        last_result,
        output ready
    );
endinterface

interface csv_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== design/csvs_front.sv =====
module csvs_front
    import csvs_pkg::*;
#(
    parameter int SPACE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    csv_in_if.sink    line,
    csv_cfg_if.sink   cfg,
    output cmd_t      cmd,
    output logic      cmd_valid,
    input  logic      cmd_ready
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);

    logic [7:0]    delimiter_reg;
    logic          iq_reg, iq_next;
    logic          qw_reg, qw_next;
    logic          fht_reg, fht_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_kind_t     kind;
    logic          plain;
    logic          accept;
    logic [7:0]    c;

    assign c = line.in_byte;
    assign line.ready = cmd_ready;
    assign cfg.ready = 1'b1;
    assign accept = line.valid && line.ready;

    always_comb
    begin
        iq_next = iq_reg;
        qw_next = qw_reg;
        fht_next = fht_reg;
        cnt_next = cnt_reg;
        kind = CMD_NONE;
        plain = 1'b0;
        if (line.in_byte_valid)
        begin
            if (qw_reg)
            begin
                qw_next = 1'b0;
                if (c == QUOTE_BYTE)
                begin
                    kind = CMD_TEXT;
                end
                else
                begin
                    iq_next = 1'b0;
                    plain = 1'b1;
                end
            end
            else
            begin
                plain = 1'b1;
            end
            if (plain)
            begin
                if (c == QUOTE_BYTE)
                begin
                    if (iq_next)
                    begin
                        qw_next = 1'b1;
                    end
                    else
                    begin
                        iq_next = 1'b1;
                    end
                end
                else if ((c == delimiter_reg) && !iq_next)
                begin
                    kind = CMD_END;
                end
                else if (is_space(c))
                begin
                    if (fht_reg)
                    begin
                        if (cnt_reg < CW'(SPACE_DEPTH))
                        begin
                            kind = CMD_STORE;
                        end
                        else
                        begin
                            kind = CMD_OVF;
                        end
                    end
                end
                else
                begin
                    kind = CMD_TEXT;
                end
            end
        end
        case (kind)
            CMD_TEXT:
            begin
                fht_next = 1'b1;
                cnt_next = '0;
            end
            CMD_END:
            begin
                fht_next = 1'b0;
                cnt_next = '0;
            end
            CMD_STORE:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        if (line.end_of_line)
        begin
            qw_next = 1'b0;
            fht_next = 1'b0;
            cnt_next = '0;
            iq_next = 1'b0;
        end
    end

    assign cmd.kind = kind;
    assign cmd.data = c;
    assign cmd.count = CNT_W'(cnt_reg);
    assign cmd.eol = line.end_of_line;
    assign cmd_valid = accept && ((kind != CMD_NONE) || line.end_of_line);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
            iq_reg <= 1'b0;
            qw_reg <= 1'b0;
            fht_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                delimiter_reg <= cfg.data;
            end
            if (accept)
            begin
                iq_reg <= iq_next;
                qw_reg <= qw_next;
                fht_reg <= fht_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ===== design/csvs_queue.sv =====
module csvs_queue
    import csvs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_cmd,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t head,
    output logic head_valid,
    input  logic pop
)
;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head = q_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/csvs_back.sv =====
module csvs_back
    import csvs_pkg::*;
#(
    parameter int SPACE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       pop,
    csv_out_if.source  fields
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_READ,
        B_FLUSH,
        B_MAIN,
        B_EOL
    } state_t;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_inc;
    logic [7:0]    mem [SPACE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          obv_reg;
    logic          fd_reg;
    logic          ld_reg;
    logic          ovf_reg;
    logic          last_reg;
    logic          can_emit;
    logic          emit_now;

    assign can_emit = !out_valid_reg || fields.ready;
    assign emit_now = can_emit && ((state_reg == B_FLUSH) || (state_reg == B_MAIN) ||
                                   (state_reg == B_EOL));
    assign pop = (state_reg == B_IDLE) && head_valid;
    assign idx_inc = idx_reg + 1'b1;

    assign fields.valid = out_valid_reg;
    assign fields.out_byte = out_byte_reg;
    assign fields.out_byte_valid = obv_reg;
    assign fields.field_done = fd_reg;
    assign fields.line_done = ld_reg;
    assign fields.space_overflow = ovf_reg;
    assign fields.last_result = last_reg;

    // held whitespace store
    always_ff @(posedge clk)
    begin
        if (pop && (head.kind == CMD_STORE))
        begin
            mem[head.count[AW-1:0]] <= head.data;
        end
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cmd_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg <= '0;
            obv_reg <= 1'b0;
            fd_reg <= 1'b0;
            ld_reg <= 1'b0;
            ovf_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && fields.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (head_valid)
                    begin
                        cmd_reg <= head;
                        idx_reg <= '0;
                        case (head.kind)
                            CMD_TEXT:
                            begin
                                state_reg <= (head.count != '0) ? B_READ : B_MAIN;
                            end
                            CMD_OVF, CMD_END:
                            begin
                                state_reg <= B_MAIN;
                            end
                            default:
                            begin
                                state_reg <= head.eol ? B_EOL : B_IDLE;
                            end
                        endcase
                    end
                end
                B_READ:
                begin
                    state_reg <= B_FLUSH;
                end
                B_FLUSH:
                begin
                    if (can_emit)
                    begin
                        out_byte_reg <= rd_data_reg;
                        obv_reg <= 1'b1;
                        fd_reg <= 1'b0;
                        ld_reg <= 1'b0;
                        ovf_reg <= 1'b0;
                        last_reg <= 1'b0;
                        idx_reg <= idx_inc;
                        state_reg <= (idx_inc == cmd_reg.count[CW-1:0]) ? B_MAIN : B_READ;
                    end
                end
                B_MAIN:
                begin
                    if (can_emit)
                    begin
                        out_byte_reg <= (cmd_reg.kind == CMD_TEXT) ? cmd_reg.data : 8'd0;
                        obv_reg <= (cmd_reg.kind == CMD_TEXT);
                        fd_reg <= (cmd_reg.kind == CMD_END);
                        ld_reg <= 1'b0;
                        ovf_reg <= (cmd_reg.kind == CMD_OVF);
                        last_reg <= !cmd_reg.eol;
                        state_reg <= cmd_reg.eol ? B_EOL : B_IDLE;
                    end
                end
                B_EOL:
                begin
                    if (can_emit)
                    begin
                        out_byte_reg <= 8'd0;
                        obv_reg <= 1'b0;
                        fd_reg <= 1'b1;
                        ld_reg <= 1'b1;
                        ovf_reg <= 1'b0;
                        last_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/csv_line_field_splitter_top.sv =====
// channel  | dir | payload                                                  | handshake
// line     | in  | in_byte, in_byte_valid, end_of_line                      | valid/ready
// fields   | out | out_byte, out_byte_valid, field_done, line_done,          | valid/ready
//          |     | space_overflow, last_result                              |
// cfg      | in  | data (delimiter)                                         | valid/ready
//
// a byte that yields one result passes the back end states B_IDLE and B_MAIN; each
// held whitespace byte flushed ahead of text adds B_READ and B_FLUSH (store read is
// registered), a line end adds B_EOL; items that make no command never reach the queue
// a two-entry command queue lets the front end keep taking bytes while results stall
// reset is asynchronous active low; delimiter comes out of reset as a comma
module csv_line_field_splitter_top
    import csvs_pkg::*;
#(
    parameter int SPACE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    csv_in_if.sink    line,
    csv_cfg_if.sink   cfg,
    csv_out_if.source fields
);

    cmd_t push_cmd;
    logic push_valid;
    logic push_ready;
    cmd_t head;
    logic head_valid;
    logic pop;

    csvs_front #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .line      (line),
        .cfg       (cfg),
        .cmd       (push_cmd),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready)
    );

    csvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    csvs_back #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .fields     (fields)
    );

endmodule

// ===== design/csvs_chk.sv =====
module csvs_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_byte_valid,
    input logic       field_done,
    input logic       line_done,
    input logic       space_overflow,
    input logic       last_result
);

    // a result carries exactly one kind of content
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({out_byte_valid, field_done, space_overflow}) == 1)
        else $error("result kind not unique");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_done) |-> (field_done && last_result))
        else $error("line end without field end or last mark");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_byte_valid) |-> (out_byte == 8'd0))
        else $error("byte not zero without content");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)
            && $stable(field_done) && $stable(last_result)))
        else $error("stalled result changed");

endmodule

bind csv_line_field_splitter_top csvs_chk u_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (fields.valid),
    .out_ready      (fields.ready),
    .out_byte       (fields.out_byte),
    .out_byte_valid (fields.out_byte_valid),
    .field_done     (fields.field_done),
    .line_done      (fields.line_done),
    .space_overflow (fields.space_overflow),
    .last_result    (fields.last_result)
);

// ===== tb/csv_line_field_splitter_checker.sv =====
`timescale 1ns / 1ps

module csv_line_field_splitter_checker
    import csvs_pkg::*;
#(
    parameter int SPACE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    csv_in_if           line,
    csv_cfg_if          cfg,
    csv_out_if          fields,
    output int          errors,
    output int unsigned outstanding
);

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_done;
        logic       line_done;
        logic       space_overflow;
        logic       last_result;
    } field_res_t;

    logic [7:0]  delim;
    logic        in_quotes;
    logic        quote_pending;
    logic        has_text;
    logic [7:0]  held_spaces [SPACE_DEPTH];
    int unsigned held_count;

    field_res_t  step_buf [SPACE_DEPTH+2];
    int          step_n;
    field_res_t  expected_fields [$];

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], 8'h20};
    endfunction

    task automatic emit(input logic [7:0] b, input logic bv, input logic fd, input logic ld,
                        input logic ovf);
        step_buf[step_n] = '{out_byte: bv ? b : 8'h00, byte_valid: bv, field_done: fd,
                             line_done: ld, space_overflow: ovf, last_result: 1'b0};
        step_n++;
    endtask

    // held whitespace goes out ahead of the text byte
    task automatic put_text(input logic [7:0] c);
        int i;
        for (i = 0; i < held_count; i++)
            emit(held_spaces[i], 1'b1, 1'b0, 1'b0, 1'b0);
        held_count = 0;
        emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
        has_text = 1'b1;
    endtask

    task automatic close_field(input logic ld);
        emit(8'h00, 1'b0, 1'b1, ld, 1'b0);
        has_text   = 1'b0;
        held_count = 0;
    endtask

    task automatic take_char(input logic [7:0] c);
        if (c == QUOTE_BYTE)
        begin
            if (in_quotes)
                quote_pending = 1'b1;
            else
                in_quotes = 1'b1;
        end
        else if (c == delim && !in_quotes)
        begin
            close_field(1'b0);
        end
        else if (is_blank(c))
        begin
            if (has_text)
            begin
                if (held_count < SPACE_DEPTH)
                begin
                    held_spaces[held_count] = c;
                    held_count++;
                end
                else
                begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                end
            end
        end
        else
        begin
            put_text(c);
        end
    endtask

    task automatic predict_item(input logic [7:0] c, input logic bv, input logic eol);
        int i;
        step_n = 0;
        if (bv)
        begin
            if (quote_pending)
            begin
                quote_pending = 1'b0;
                if (c == QUOTE_BYTE)
                begin
                    put_text(c);
                end
                else
                begin
                    in_quotes = 1'b0;
                    take_char(c);
                end
            end
            else
            begin
                take_char(c);
            end
        end
        if (eol)
        begin
            quote_pending = 1'b0;
            close_field(1'b1);
            in_quotes = 1'b0;
        end
        if (step_n > 0)
            step_buf[step_n-1].last_result = 1'b1;
        for (i = 0; i < step_n; i++)
            expected_fields.push_back(step_buf[i]);
    endtask

    always @(posedge clk)
    begin
        field_res_t got;
        field_res_t want;
        if (!rst_n)
        begin
            delim         = DELIM_RESET;
            in_quotes     = 1'b0;
            quote_pending = 1'b0;
            has_text      = 1'b0;
            held_count    = 0;
            expected_fields.delete();
            errors        = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                delim = cfg.data;
            if (line.valid && line.ready)
                predict_item(line.in_byte, line.in_byte_valid, line.end_of_line);
            if (fields.valid && fields.ready)
            begin
                got = '{out_byte: fields.out_byte, byte_valid: fields.out_byte_valid,
                        field_done: fields.field_done, line_done: fields.line_done,
                        space_overflow: fields.space_overflow,
                        last_result: fields.last_result};
                if (expected_fields.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch: expected byte %h bv %b fd %b ld %b ovf %b last %b, got byte %h bv %b fd %b ld %b ovf %b last %b",
                                 $time, want.out_byte, want.byte_valid, want.field_done,
                                 want.line_done, want.space_overflow, want.last_result,
                                 got.out_byte, got.byte_valid, got.field_done,
                                 got.line_done, got.space_overflow, got.last_result);
                        errors++;
                    end
                end
            end
            outstanding = expected_fields.size();
        end
    end

endmodule

// ===== tb/csv_line_field_splitter_top_tb.sv =====
`timescale 1ns / 1ps

module csv_line_field_splitter_top_tb;
    import csvs_pkg::*;

    localparam int SPACE_DEPTH   = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 20;
    localparam int PHASE_ITEMS   = 33;

    logic        clk;
    logic        rst_n;
    int          errors;
    int unsigned outstanding;
    int          idle_cycles;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          phase_items;
    logic [7:0]  delim;
    logic [7:0]  line_bytes [$];

    logic [7:0]  delim_list [6] = '{8'd44, 8'h00, 8'hFF, QUOTE_BYTE, 8'h09, 8'h3B};
    int          src_pct_list [4] = '{0, 58, 0, 22};
    int          sink_pct_list [4] = '{0, 0, 58, 22};

    csv_in_if  line_ch();
    csv_cfg_if cfg_ch();
    csv_out_if fields_ch();

    csv_line_field_splitter_top #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_ch),
        .cfg    (cfg_ch),
        .fields (fields_ch)
    );

    csv_line_field_splitter_checker #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .line        (line_ch),
        .cfg         (cfg_ch),
        .fields      (fields_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial fields_ch.ready = 1'b0;
    always @(negedge clk)
        fields_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((line_ch.valid && line_ch.ready) || (fields_ch.valid && fields_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("csv_line_field_splitter_top_tb: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic bv, input logic eol);
        while ($urandom_range(99) < src_idle_pct)
        begin
            line_ch.valid <= 1'b0;
            @(negedge clk);
        end
        line_ch.valid         <= 1'b1;
        line_ch.in_byte       <= b;
        line_ch.in_byte_valid <= bv;
        line_ch.end_of_line   <= eol;
        do
            @(posedge clk);
        while (!line_ch.ready);
        @(negedge clk);
        if (bv || eol)
            phase_items++;
    endtask

    // hold off the sender until every expected result is back, then let the block settle
    task automatic drain();
        line_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_delim(input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        delim = v;
    endtask

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(8'h0D, 8'h09));
        return 8'h20;
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == QUOTE_BYTE || b == delim || b inside {[8'h09:8'h0D], 8'h20});
        return b;
    endfunction

    task automatic build_field();
        int kind;
        int n;
        int i;
        kind = $urandom_range(9);
        if (kind <= 3)
        begin
            repeat ($urandom_range(2)) line_bytes.push_back(pick_blank());
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(3) == 0)
                    repeat ($urandom_range(1, 2)) line_bytes.push_back(pick_blank());
                line_bytes.push_back(pick_text());
            end
            repeat ($urandom_range(2)) line_bytes.push_back(pick_blank());
        end
        else if (kind <= 6)
        begin
            line_bytes.push_back(QUOTE_BYTE);
            n = $urandom_range(4);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(4))
                    0, 1: line_bytes.push_back(pick_text());
                    2: line_bytes.push_back(pick_blank());
                    3: line_bytes.push_back(delim);
                    default:
                    begin
                        line_bytes.push_back(QUOTE_BYTE);
                        line_bytes.push_back(QUOTE_BYTE);
                    end
                endcase
            end
            line_bytes.push_back(QUOTE_BYTE);
            if ($urandom_range(2) == 0)
                line_bytes.push_back(pick_blank());
        end
        else if (kind == 7)
        begin
            // long whitespace run, may fill the store
            line_bytes.push_back(pick_text());
            repeat ($urandom_range(12, 20)) line_bytes.push_back(pick_blank());
            if ($urandom_range(1) == 1)
                line_bytes.push_back(pick_text());
        end
        else
        begin
            n = $urandom_range(6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(3) == 0)
                    line_bytes.push_back(QUOTE_BYTE);
                else
                    line_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_random_line();
        int nf;
        int f;
        int i;
        logic split_end;
        line_bytes.delete();
        nf = $urandom_range(1, 4);
        for (f = 0; f < nf; f++)
        begin
            if (f > 0)
                line_bytes.push_back(delim);
            build_field();
        end
        split_end = (line_bytes.size() == 0) || ($urandom_range(5) == 0);
        for (i = 0; i < line_bytes.size(); i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(line_bytes[i], 1'b1, !split_end && (i == line_bytes.size() - 1));
        end
        if (split_end)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int p;
        logic paused;
        rst_n                 = 1'b0;
        idle_cycles           = 0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;
        phase_items           = 0;
        delim                 = DELIM_RESET;
        line_ch.valid         = 1'b0;
        line_ch.in_byte       = 8'h00;
        line_ch.in_byte_valid = 1'b0;
        line_ch.end_of_line   = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = 8'h00;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line
        send_item(8'h00, 1'b0, 1'b1);
        // trimming and held whitespace
        send_item(8'h09, 1'b1, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item(8'h0D, 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item(",", 1'b1, 1'b0);
        // doubled quote, then pending quote closed by whitespace
        send_item(QUOTE_BYTE, 1'b1, 1'b0);
        send_item(QUOTE_BYTE, 1'b1, 1'b0);
        send_item(QUOTE_BYTE, 1'b1, 1'b0);
        send_item("x", 1'b1, 1'b0);
        send_item(QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item(",", 1'b1, 1'b0);
        // delimiter inside quotes, pending quote at line end
        send_item(QUOTE_BYTE, 1'b1, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item(",", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item(QUOTE_BYTE, 1'b1, 1'b1);
        // byte extremes and an item with no character and no line end
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        for (p = 0; p < 6; p++)
        begin
            drain();
            write_delim(delim_list[p]);
            src_idle_pct   = src_pct_list[p % 4];
            sink_stall_pct = sink_pct_list[p % 4];
            phase_items    = 0;
            paused         = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (p == 2 && !paused && phase_items >= 20)
                begin
                    drain();
                    paused = 1'b1;
                end
                send_random_line();
            end
        end

        line_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("csv_line_field_splitter_top_tb: done, clean");
        else
            $display("csv_line_field_splitter_top_tb: done, errors");
        $finish;
    end

endmodule
